### hw/rtl/sfp_pkg.sv
// Shared types and constants of the serial frame parser.
package sfp_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CfgIdxW = 2;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_FIRST_HEADER  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SECOND_HEADER = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH    = 2'd2;

	localparam logic [ByteW-1:0] RST_FIRST_HEADER  = 8'd170;
	localparam logic [ByteW-1:0] RST_SECOND_HEADER = 8'd85;
	localparam logic [ByteW-1:0] RST_MAX_LENGTH    = 8'd255;

	typedef enum logic [1:0] {
		KIND_BODY = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_BAD  = 2'd2,
		KIND_LONG = 2'd3
	} kind_t;

	typedef struct packed {
		logic [ByteW-1:0] first_header;
		logic [ByteW-1:0] second_header;
		logic [ByteW-1:0] max_body_length;
	} cfg_t;

	typedef struct packed {
		kind_t            kind;
		logic [ByteW-1:0] data_byte;
		logic [ByteW-1:0] command_code;
		logic [ByteW-1:0] body_length;
		logic             frame_end;
	} res_t;

endpackage

### hw/rtl/sfp_cfg.sv
// Configuration registers of the serial frame parser.
module sfp_cfg import sfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ByteW-1:0]   cfg_wdata,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_header    <= RST_FIRST_HEADER;
			cfg_q.second_header   <= RST_SECOND_HEADER;
			cfg_q.max_body_length <= RST_MAX_LENGTH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIRST_HEADER:  cfg_q.first_header    <= cfg_wdata;
				REG_SECOND_HEADER: cfg_q.second_header   <= cfg_wdata;
				REG_MAX_LENGTH:    cfg_q.max_body_length <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/sfp_core.sv
// Frame state machine: per-byte phase, checksum and length tracking.
module sfp_core import sfp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	input  logic [ByteW-1:0] rx_byte,
	output logic             res_valid,
	output res_t             res
);

	typedef enum logic [5:0] {
		PH_HUNT1 = 6'b000001,
		PH_HUNT2 = 6'b000010,
		PH_CMD   = 6'b000100,
		PH_LEN   = 6'b001000,
		PH_BODY  = 6'b010000,
		PH_CHECK = 6'b100000
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [ByteW-1:0] sum_q, sum_d;
	logic [ByteW-1:0] cmd_q, cmd_d;
	logic [ByteW-1:0] len_q, len_d;
	logic [ByteW-1:0] left_q, left_d;
	logic [ByteW-1:0] left_dec;
	logic [ByteW-1:0] sum_add;

	assign left_dec = left_q - 8'd1;
	assign sum_add  = sum_q + rx_byte;

	always_comb begin
		phase_d   = phase_q;
		sum_d     = sum_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		left_d    = left_q;
		res_valid = 1'b0;
		res.kind         = KIND_BODY;
		res.data_byte    = rx_byte;
		res.command_code = cmd_q;
		res.body_length  = len_q;
		res.frame_end    = 1'b0;
		case (phase_q)
			PH_HUNT2: begin
				if (rx_byte == cfg.second_header) begin
					sum_d   = sum_add;
					phase_d = PH_CMD;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_CMD: begin
				cmd_d   = rx_byte;
				sum_d   = sum_add;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d = rx_byte;
				sum_d = sum_add;
				if (rx_byte > cfg.max_body_length) begin
					phase_d          = PH_HUNT1;
					res_valid        = 1'b1;
					res.kind         = KIND_LONG;
					res.body_length  = rx_byte;
					res.frame_end    = 1'b1;
				end else begin
					left_d  = rx_byte;
					phase_d = (rx_byte == '0) ? PH_CHECK : PH_BODY;
				end
			end
			PH_BODY: begin
				sum_d     = sum_add;
				left_d    = left_dec;
				res_valid = 1'b1;
				if (left_dec == '0) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				phase_d       = PH_HUNT1;
				res_valid     = 1'b1;
				res.kind      = (rx_byte == sum_q) ? KIND_GOOD : KIND_BAD;
				res.frame_end = 1'b1;
			end
			default: begin
				// Hunting; a new first header restarts the sum at that byte.
				if (rx_byte == cfg.first_header) begin
					sum_d   = rx_byte;
					phase_d = PH_HUNT2;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			sum_q   <= '0;
			cmd_q   <= '0;
			len_q   <= '0;
			left_q  <= '0;
		end else if (in_valid) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			left_q  <= left_d;
		end
	end

endmodule

### hw/rtl/sfp_out.sv
// Result register with a skid stage toward the output stream.
module sfp_out import sfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic ready,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic pop;

	assign pop   = out_valid_q && out_ready;
	// Ready comes from a register only, so the input never waits on the output path.
	assign ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_res;
			end else begin
				out_q <= push_res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

### hw/rtl/serial_frame_parser.sv
// Top level of the serial frame parser.
//
// Bytes from a serial receiver enter on the s_ stream, one byte per beat.
// The parser hunts for two header bytes, then takes a command byte, a length
// byte, the body and a checksum byte (8-bit wrapping sum of all prior bytes).
// Each body byte leaves on the m_ stream as kind body; the frame closes with
// one beat of kind good, checksum error or length too long, with m_tlast set.
// Header and stray bytes produce no output beat.
// One byte per cycle while s_tready is high: the per-byte update is a single
// compare and 8-bit add between the state registers and the result register.
// The result beat of an accepted byte is registered in the result register or the skid.
// A two-entry output buffer (result register plus skid) decouples the sides;
// s_tready drops only when both entries hold results the receiver has not
// taken, and returns the cycle after the next beat leaves.
// Reset clears the parser to header hunting and loads the register defaults
// (first header 170, second header 85, maximum length 255); output is empty.
// Configuration writes take effect on the next clock edge.
module serial_frame_parser import sfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ByteW-1:0]   cfg_wdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] rx_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,   // [7:0] data_byte, [15:8] command_code,
	                                      // [23:16] body_length
	output logic [1:0]         m_tuser,   // [1:0] kind
	output logic               m_tlast    // frame_end
);

	cfg_t cfg;
	logic accept;
	logic res_valid;
	res_t res;
	res_t out_res;

	assign accept = s_tvalid && s_tready;

	sfp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sfp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (accept),
		.rx_byte   (s_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	sfp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_res  (res),
		.ready     (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {out_res.body_length, out_res.command_code, out_res.data_byte};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.frame_end;

endmodule

### sim/testbench.sv
// Self-checking testbench of the serial frame parser: random framed traffic against a predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sfp_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int PRINT_LIMIT = 30;

	typedef enum logic [2:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		GET_CMD,
		GET_LEN,
		GET_BODY,
		GET_CHECK
	} parse_phase_e;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = REG_FIRST_HEADER;
	logic [ByteW-1:0]   cfg_wdata = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;    // [7:0] rx_byte
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [23:0]        m_tdata;         // [7:0] data_byte, [15:8] command_code,
	                                     // [23:16] body_length
	logic [1:0]         m_tuser;         // [1:0] kind
	logic               m_tlast;         // frame_end

	// Register copy and parser state of the predictor.
	cfg_t         cur_cfg = '{RST_FIRST_HEADER, RST_SECOND_HEADER, RST_MAX_LENGTH};
	parse_phase_e mdl_phase = HUNT_FIRST;
	logic [7:0]   mdl_sum = '0;
	logic [7:0]   mdl_cmd = '0;
	logic [7:0]   mdl_len = '0;
	logic [7:0]   mdl_left = '0;

	logic [7:0] rx_pending[$];
	res_t       pending_results[$];
	res_t       front_result;

	int  bytes_queued = 0;
	int  bytes_accepted = 0;
	int  beats_seen = 0;
	int  kind_seen[4] = '{0, 0, 0, 0};
	int  error_count = 0;
	int  settings_used = 0;
	int  idle_cycles = 0;
	int  burst_left = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	bit  no_idle = 1'b0;

	serial_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Advances the parser by one received byte and records the beat it causes.
	function automatic void parse_byte(input logic [7:0] b);
		res_t r;
		bit   has_beat;
		r = '0;
		has_beat = 1'b0;
		case (mdl_phase)
			HUNT_SECOND: begin
				if (b == cur_cfg.second_header) begin
					mdl_sum = mdl_sum + b;
					mdl_phase = GET_CMD;
				end else begin
					mdl_phase = HUNT_FIRST;
				end
			end
			GET_CMD: begin
				mdl_cmd = b;
				mdl_sum = mdl_sum + b;
				mdl_phase = GET_LEN;
			end
			GET_LEN: begin
				mdl_len = b;
				mdl_sum = mdl_sum + b;
				if (b > cur_cfg.max_body_length) begin
					mdl_phase = HUNT_FIRST;
					r.kind = KIND_LONG;
					r.data_byte = b;
					r.frame_end = 1'b1;
					has_beat = 1'b1;
				end else begin
					mdl_left = b;
					mdl_phase = (b == 8'd0) ? GET_CHECK : GET_BODY;
				end
			end
			GET_BODY: begin
				mdl_sum = mdl_sum + b;
				mdl_left = mdl_left - 8'd1;
				if (mdl_left == 8'd0)
					mdl_phase = GET_CHECK;
				r.kind = KIND_BODY;
				r.data_byte = b;
				r.frame_end = 1'b0;
				has_beat = 1'b1;
			end
			GET_CHECK: begin
				mdl_phase = HUNT_FIRST;
				r.kind = (b == mdl_sum) ? KIND_GOOD : KIND_BAD;
				r.data_byte = b;
				r.frame_end = 1'b1;
				has_beat = 1'b1;
			end
			default: begin
				if (b == cur_cfg.first_header) begin
					mdl_sum = b;
					mdl_phase = HUNT_SECOND;
				end else begin
					mdl_phase = HUNT_FIRST;
				end
			end
		endcase
		if (has_beat) begin
			r.command_code = mdl_cmd;
			r.body_length = mdl_len;
			pending_results.push_back(r);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("%0t: mismatch on %s at output beat %0d: got %h, expected %h",
				$realtime, what, beats_seen, got, want);
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (s_tvalid) begin
				bytes_accepted++;
				parse_byte(s_tdata);
			end
			if (gap_left > 0 && !no_idle) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (rx_pending.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= rx_pending.pop_front();
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: ready most of the time, with stalls of random length now and then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				kind_seen[m_tuser]++;
				if (pending_results.size() == 0) begin
					report_mismatch("kind of a beat with nothing pending", 8'(m_tuser), 8'd0);
				end else begin
					front_result = pending_results.pop_front();
					if (m_tuser !== front_result.kind)
						report_mismatch("kind", 8'(m_tuser), 8'(front_result.kind));
					if (m_tdata[7:0] !== front_result.data_byte)
						report_mismatch("data_byte", m_tdata[7:0], front_result.data_byte);
					if (m_tdata[15:8] !== front_result.command_code)
						report_mismatch("command_code", m_tdata[15:8],
							front_result.command_code);
					if (m_tdata[23:16] !== front_result.body_length)
						report_mismatch("body_length", m_tdata[23:16],
							front_result.body_length);
					if (m_tlast !== front_result.frame_end)
						report_mismatch("frame_end", 8'(m_tlast), 8'(front_result.frame_end));
				end
				beats_seen++;
			end
			if (no_idle) begin
				stall_left = 0;
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any beat or register write.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $realtime, IDLE_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		rx_pending.push_back(b);
		bytes_queued++;
	endtask

	// Queues a frame under the current headers; an overlong frame stops at its length byte.
	task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] len,
			input bit bad_sum);
		logic [7:0] sum;
		logic [7:0] b;
		queue_byte(cur_cfg.first_header);
		queue_byte(cur_cfg.second_header);
		queue_byte(cmd);
		queue_byte(len);
		sum = cur_cfg.first_header + cur_cfg.second_header + cmd + len;
		if (len > cur_cfg.max_body_length)
			return;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			queue_byte(b);
			sum = sum + b;
		end
		queue_byte(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
	endtask

	// Mostly well-formed frames, plus stray bytes, bad second headers and cut frames.
	task automatic queue_mixed_traffic(input int n);
		int         stop_at;
		int         pick;
		int         mx;
		int         lim;
		logic [7:0] len;
		logic [7:0] b;
		stop_at = bytes_queued + n;
		mx = int'(cur_cfg.max_body_length);
		lim = (mx < 12) ? mx : 12;
		while (bytes_queued < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				case ($urandom_range(0, 9))
					0: len = 8'((mx <= 40) ? mx : $urandom_range(13, 40));
					1: len = 8'((mx < 255) ? $urandom_range(mx + 1, 255) : $urandom_range(0, lim));
					default: len = 8'($urandom_range(0, lim));
				endcase
				queue_frame(8'($urandom), len, $urandom_range(0, 5) == 0);
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 4))
					queue_byte(8'($urandom));
			end else if (pick < 96 || mx == 0) begin
				b = 8'($urandom);
				if (b == cur_cfg.second_header)
					b = ~b;
				queue_byte(cur_cfg.first_header);
				queue_byte(b);
			end else begin
				// The missing tail is made up by whatever bytes follow.
				len = 8'($urandom_range(1, (mx < 8) ? mx : 8));
				queue_byte(cur_cfg.first_header);
				queue_byte(cur_cfg.second_header);
				queue_byte(8'($urandom));
				queue_byte(len);
				repeat ($urandom_range(0, len - 1))
					queue_byte(8'($urandom));
			end
		end
	endtask

	// Waits until every queued byte has been sent and every pending result has been taken.
	task automatic drain_results();
		while (rx_pending.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FIRST_HEADER:  cur_cfg.first_header = value;
			REG_SECOND_HEADER: cur_cfg.second_header = value;
			REG_MAX_LENGTH:    cur_cfg.max_body_length = value;
			default: ;
		endcase
	endtask

	task automatic set_all_regs(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] max_len);
		set_reg(REG_FIRST_HEADER, first);
		set_reg(REG_SECOND_HEADER, second);
		set_reg(REG_MAX_LENGTH, max_len);
		settings_used++;
	endtask

	initial begin
		logic [7:0] hdr;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Power-on registers: stray bytes, shortest frame, a repeated first header.
		settings_used++;
		queue_byte(8'h00);
		queue_byte(8'hff);
		queue_frame(8'hff, 8'd0, 1'b0);
		queue_byte(cur_cfg.first_header);
		queue_byte(cur_cfg.first_header);
		queue_byte(cur_cfg.second_header);
		queue_frame(8'h00, 8'd2, 1'b1);
		queue_frame(8'($urandom), 8'd255, 1'b0);
		queue_mixed_traffic(100);
		drain_results();

		// Zero maximum length; a write to the unused index must change nothing.
		set_all_regs(8'h00, 8'hff, 8'd0);
		set_reg(REG_UNUSED, 8'h5a);
		queue_frame(8'h5a, 8'd0, 1'b0);
		queue_frame(8'ha5, 8'd1, 1'b0);
		queue_frame(8'h3c, 8'd255, 1'b0);
		queue_mixed_traffic(250);
		drain_results();

		// Pause in the middle of the traffic until the output side has caught up.
		set_all_regs(8'hff, 8'h00, 8'd16);
		queue_frame(8'($urandom), 8'd16, 1'b0);
		queue_frame(8'($urandom), 8'd17, 1'b0);
		queue_mixed_traffic(150);
		drain_results();
		queue_mixed_traffic(150);
		drain_results();

		// Random registers; the first half runs with neither side idling.
		set_all_regs(8'($urandom), 8'($urandom), 8'($urandom_range(1, 40)));
		no_idle = 1'b1;
		queue_mixed_traffic(200);
		drain_results();
		no_idle = 1'b0;
		queue_mixed_traffic(200);
		drain_results();

		// Both headers equal.
		hdr = 8'($urandom);
		set_all_regs(hdr, hdr, 8'($urandom_range(1, 8)));
		queue_mixed_traffic(250);
		drain_results();

		// Power-on values written back explicitly.
		set_all_regs(RST_FIRST_HEADER, RST_SECOND_HEADER, RST_MAX_LENGTH);
		queue_mixed_traffic(200);
		drain_results();

		$display("Sent %0d bytes under %0d register settings and checked %0d output beats.",
			bytes_accepted, settings_used, beats_seen);
		$display("Beats by kind: %0d body, %0d good frame, %0d checksum error, %0d too long.",
			kind_seen[KIND_BODY], kind_seen[KIND_GOOD], kind_seen[KIND_BAD],
			kind_seen[KIND_LONG]);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches found", error_count);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
